FILE: rtl/pvs_pkg.sv
package pvs_pkg;

    // field widths of the item channels
    localparam int FI_W    = 4;
    localparam int PAGE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CLASS_W = 2;
    localparam int VF_W    = 4;

    // configuration port
    localparam int FIU_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    // replacement policies
    localparam logic POL_LRU = 1'b0;
    localparam logic POL_NRU = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // reset values
    localparam logic [FIU_W-1:0] FRAMES_RESET = 5'd16;

    typedef struct packed {
        logic             policy;
        logic [FIU_W-1:0] frames_in_use;
    } t_cfg;

    // one frame table entry as stored in the ram
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              referenced;
        logic              modified;
        logic [TIME_W-1:0] last_access;
    } t_frame_entry;

endpackage

FILE: rtl/pvs_stream_if.sv
interface pvs_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [pvs_pkg::FI_W-1:0]   frame_index;
    logic [pvs_pkg::PAGE_W-1:0] page_index;
    logic                       referenced;
    logic                       modified;
    logic [pvs_pkg::TIME_W-1:0] access_time;
    logic [pvs_pkg::TIME_W-1:0] current_time;

    modport source (
        output valid, mode, frame_index, page_index, referenced, modified,
               access_time, current_time,
        input  ready
    );
    modport sink (
        input  valid, mode, frame_index, page_index, referenced, modified,
               access_time, current_time,
        output ready
    );
endinterface

interface pvs_out_if;
    logic                        valid;
    logic                        ready;
    logic [pvs_pkg::VF_W-1:0]    victim_frame;
    logic [pvs_pkg::PAGE_W-1:0]  victim_page;
    logic [pvs_pkg::CLASS_W-1:0] victim_class;

    modport source (
        output valid, victim_frame, victim_page, victim_class,
        input  ready
    );
    modport sink (
        input  valid, victim_frame, victim_page, victim_class,
        output ready
    );
endinterface

FILE: rtl/pvs_ram.sv
module pvs_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/pvs_cfg_regs.sv
module pvs_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pvs_pkg::ADDR_W-1:0]   paddr,
    input  logic [pvs_pkg::DATA_W-1:0]   pwdata,
    output logic [pvs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output pvs_pkg::t_cfg                o_cfg
);
    import pvs_pkg::*;

    logic             r_policy;
    logic [FIU_W-1:0] r_frames_in_use;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy        <= POL_LRU;
            r_frames_in_use <= FRAMES_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_POLICY: r_policy        <= pwdata[0];
                REG_FRAMES: r_frames_in_use <= pwdata[FIU_W-1:0];
                default:    r_policy        <= r_policy;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            REG_POLICY: prdata = {{(DATA_W-1){1'b0}}, r_policy};
            REG_FRAMES: prdata = {{(DATA_W-FIU_W){1'b0}}, r_frames_in_use};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.policy        = r_policy;
    assign o_cfg.frames_in_use = r_frames_in_use;
endmodule

FILE: rtl/pvs_scan_engine.sv
module pvs_scan_engine #(
    parameter int NUM_FRAMES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pvs_pkg::t_cfg i_cfg,
    pvs_in_if.sink        i_in,
    pvs_out_if.source     o_out
);
    import pvs_pkg::*;

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int LW = (AW > FIU_W) ? AW : FIU_W;
    localparam int EW = $bits(t_frame_entry);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_idx, n_idx;
    logic [LW-1:0]       r_last, n_last;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    logic [PAGE_W-1:0]   r_best_page, n_best_page;
    logic [CLASS_W-1:0]  r_best_cls, n_best_cls;
    logic [TIME_W-1:0]   r_best_age, n_best_age;
    logic                r_out_valid;
    logic [VF_W-1:0]     r_out_frame;
    logic [PAGE_W-1:0]   r_out_page;
    logic [CLASS_W-1:0]  r_out_class;

    logic                accept;
    logic                wr_in_range;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    t_frame_entry        wr_entry;
    t_frame_entry        rd_entry;
    logic [LW-1:0]       last_idx;
    logic [CLASS_W-1:0]  cand_cls;
    logic [TIME_W-1:0]   cand_age;
    logic                take;
    logic                at_last;
    logic                out_free;
    logic                out_load;
    logic [AW-1:0]       fin_idx;
    logic [PAGE_W-1:0]   fin_page;
    logic [CLASS_W-1:0]  fin_cls;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // table write for a write transfer
    assign wr_in_range          = (32'(i_in.frame_index) < NUM_FRAMES);
    assign ram_we               = accept && (i_in.mode == MODE_WRITE) && wr_in_range;
    assign ram_waddr            = AW'(i_in.frame_index);
    assign wr_entry.page        = i_in.page_index;
    assign wr_entry.referenced  = i_in.referenced;
    assign wr_entry.modified    = i_in.modified;
    assign wr_entry.last_access = i_in.access_time;

    // frame 0 is fetched at the select transfer, then one frame ahead
    assign ram_raddr = (r_state == S_IDLE) ? '0 : r_idx + AW'(1);

    pvs_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    // scan length clamped to one .. NUM_FRAMES
    always_comb begin
        if (i_cfg.frames_in_use == '0) begin
            last_idx = '0;
        end else if (32'(i_cfg.frames_in_use) > NUM_FRAMES) begin
            last_idx = LW'(NUM_FRAMES - 1);
        end else begin
            last_idx = LW'(i_cfg.frames_in_use - 1'b1);
        end
    end

    // candidate compare against the best so far
    assign cand_cls = {rd_entry.referenced, rd_entry.modified};
    assign cand_age = r_now - rd_entry.last_access;
    assign at_last  = (LW'(r_idx) == r_last);

    always_comb begin
        if (r_idx == '0) begin
            take = 1'b1;
        end else if (i_cfg.policy == POL_LRU) begin
            take = (cand_age > r_best_age);
        end else begin
            // lower class wins; in a nonzero class the later frame wins
            take = (cand_cls < r_best_cls) ||
                   ((cand_cls == r_best_cls) && (cand_cls != '0));
        end
    end

    always_comb begin
        n_best_idx  = r_best_idx;
        n_best_page = r_best_page;
        n_best_cls  = r_best_cls;
        n_best_age  = r_best_age;
        if ((r_state == S_SCAN) && take) begin
            n_best_idx  = r_idx;
            n_best_page = rd_entry.page;
            n_best_cls  = cand_cls;
            n_best_age  = cand_age;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_last  = r_last;
        n_now   = r_now;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in.mode == MODE_SELECT)) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_last  = last_idx;
                    n_now   = i_in.current_time;
                end
            end
            S_SCAN: begin
                if (at_last) begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result source: straight from the last compare, or held after a stall
    assign out_load = out_free && (((r_state == S_SCAN) && at_last) || (r_state == S_DONE));
    assign fin_idx  = (r_state == S_DONE) ? r_best_idx  : n_best_idx;
    assign fin_page = (r_state == S_DONE) ? r_best_page : n_best_page;
    assign fin_cls  = (r_state == S_DONE) ? r_best_cls  : n_best_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_best_idx  <= n_best_idx;
        r_best_page <= n_best_page;
        r_best_cls  <= n_best_cls;
        r_best_age  <= n_best_age;
        if (out_load) begin
            r_out_frame <= VF_W'(fin_idx);
            r_out_page  <= fin_page;
            r_out_class <= (i_cfg.policy == POL_NRU) ? fin_cls : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.victim_frame = r_out_frame;
    assign o_out.victim_page  = r_out_page;
    assign o_out.victim_class = r_out_class;

    // scan index stays inside the latched scan length
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (LW'(r_idx) <= r_last))
        else $error("scan index past last frame");

    // no table write while a select is in flight
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !ram_we)
        else $error("table write during scan");

    // a held result only waits behind an untaken one
    a_done_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_out_valid)
        else $error("result held with free output");

    // a new result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SCAN || $past(r_state) == S_DONE))
        else $error("result without scan");
endmodule

FILE: rtl/page_victim_selector_unit.sv
// channel   dir  handshake        payload
// i_in      in   valid / ready    mode, frame_index, page_index, referenced,
//                                 modified, access_time, current_time
// o_out     out  valid / ready    victim_frame, victim_page, victim_class
// apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// a write transfer updates one frame entry in the table ram
// a select transfer scans n frames, n = frames_in_use clamped to 1..NUM_FRAMES,
// the single ram read port fetching one frame entry per cycle
// the result waits in an output register; a select finishing behind an untaken
// result holds until the output frees
// i_rst_n is synchronous active low; the frame table is not cleared
module page_victim_selector_unit #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pvs_pkg::ADDR_W-1:0] paddr,
    input  logic [pvs_pkg::DATA_W-1:0] pwdata,
    output logic [pvs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    pvs_in_if.sink                     i_in,
    pvs_out_if.source                  o_out
);
    import pvs_pkg::*;

    t_cfg cfg;

    // configuration registers
    pvs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame table and victim scan
    pvs_scan_engine #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

FILE: tb/pvs_victim_checker.sv
`timescale 1ns / 100ps

module pvs_victim_checker #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pvs_in_if                          mon_in,
    pvs_out_if                         mon_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [pvs_pkg::ADDR_W-1:0] paddr,
    input  logic [pvs_pkg::DATA_W-1:0] pwdata,
    input  logic [pvs_pkg::DATA_W-1:0] prdata,
    output int                         o_errors,
    output int                         o_pending
);
    import pvs_pkg::*;

    typedef struct packed {
        logic [VF_W-1:0]    frame;
        logic [PAGE_W-1:0]  page;
        logic [CLASS_W-1:0] nru_class;
    } t_victim;

    // shadow of the configuration registers and of the frame table
    t_cfg         cfg;
    t_frame_entry frame_shadow [NUM_FRAMES];
    t_victim      victims_due [$];
    int           mismatches = 0;

    // victim the block should name for a select at tick now
    function automatic t_victim choose_victim(input logic [TIME_W-1:0] now);
        t_victim           v;
        int                n;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        logic [1:0]        c;
        logic [3:0]        seen;
        int                last_of [4];
        bit                found;
        v      = '0;
        found  = 1'b0;
        seen   = '0;
        oldest = '0;
        n = cfg.frames_in_use;
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        if (cfg.policy == POL_LRU) begin
            // largest wrapping age, lowest index on a tie
            for (int f = 0; f < n; f++) begin
                age = now - frame_shadow[f].last_access;
                if (f == 0 || age > oldest) begin
                    oldest  = age;
                    v.frame = VF_W'(f);
                end
            end
        end else begin
            // first frame of class zero, else the last frame of the lowest class seen
            for (int f = 0; f < n && !found; f++) begin
                c = {frame_shadow[f].referenced, frame_shadow[f].modified};
                if (c == 2'd0) begin
                    v.frame = VF_W'(f);
                    found   = 1'b1;
                end else begin
                    seen[c]    = 1'b1;
                    last_of[c] = f;
                end
            end
            for (int k = 1; k < 4 && !found; k++) begin
                if (seen[k]) begin
                    v.frame = VF_W'(last_of[k]);
                    found   = 1'b1;
                end
            end
            v.nru_class = {frame_shadow[v.frame].referenced, frame_shadow[v.frame].modified};
        end
        v.page = frame_shadow[v.frame].page;
        return v;
    endfunction

    task automatic flag_field(input string field, input longint unsigned want,
                              input longint unsigned got);
        mismatches++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_victim           want;
        logic [DATA_W-1:0] reg_value;
        if (!i_rst_n) begin
            cfg.policy        = POL_LRU;
            cfg.frames_in_use = FRAMES_RESET;
            victims_due.delete();
        end else begin
            // register access phase
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_POLICY) cfg.policy = pwdata[0];
                    else cfg.frames_in_use = pwdata[FIU_W-1:0];
                end else begin
                    reg_value = (paddr[2] == REG_POLICY) ? DATA_W'(cfg.policy)
                                                         : DATA_W'(cfg.frames_in_use);
                    if (prdata !== reg_value) flag_field("prdata", reg_value, prdata);
                end
            end

            // input transfer updates the table or queues a victim
            if (mon_in.valid && mon_in.ready) begin
                if (mon_in.mode == MODE_WRITE) begin
                    frame_shadow[mon_in.frame_index] = '{
                        page:        mon_in.page_index,
                        referenced:  mon_in.referenced,
                        modified:    mon_in.modified,
                        last_access: mon_in.access_time
                    };
                end else begin
                    victims_due.push_back(choose_victim(mon_in.current_time));
                end
            end

            // output transfer against the oldest queued victim
            if (mon_out.valid && mon_out.ready) begin
                if (victims_due.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none actual frame %0h page %0h class %0h",
                             $time, mon_out.victim_frame, mon_out.victim_page,
                             mon_out.victim_class);
                end else begin
                    want = victims_due.pop_front();
                    if (mon_out.victim_frame !== want.frame)
                        flag_field("victim_frame", want.frame, mon_out.victim_frame);
                    if (mon_out.victim_page !== want.page)
                        flag_field("victim_page", want.page, mon_out.victim_page);
                    if (mon_out.victim_class !== want.nru_class)
                        flag_field("victim_class", want.nru_class, mon_out.victim_class);
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= victims_due.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import pvs_pkg::*;

    localparam int NUM_FRAMES      = 16;
    localparam int DRAIN_CYCLES    = NUM_FRAMES + 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 70;

    typedef struct packed {
        logic              mode;
        logic [FI_W-1:0]   frame_index;
        logic [PAGE_W-1:0] page_index;
        logic              referenced;
        logic              modified;
        logic [TIME_W-1:0] access_time;
        logic [TIME_W-1:0] current_time;
    } t_stim;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                err_total;
    int                victims_pending;
    int                cycles;
    bit                quiet;

    pvs_in_if  in_ch ();
    pvs_out_if out_ch ();

    page_victim_selector_unit #(.NUM_FRAMES(NUM_FRAMES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pvs_victim_checker #(.NUM_FRAMES(NUM_FRAMES)) victim_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .mon_in    (in_ch),
        .mon_out   (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_errors  (err_total),
        .o_pending (victims_pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side backpressure
    always @(posedge i_clk) begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 7);
    end

    // one apb transfer: setup, access, then a return to idle with psel low
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both registers with junk in the unused bits, then read them back
    task automatic set_config(input logic pol, input logic [FIU_W-1:0] frames);
        apb_access(1'b1, {REG_POLICY, 2'b00}, ($urandom() & ~32'h1) | DATA_W'(pol));
        apb_access(1'b1, {REG_FRAMES, 2'b00}, ($urandom() & ~32'h1F) | DATA_W'(frames));
        apb_access(1'b0, {REG_POLICY, 2'b00}, '0);
        apb_access(1'b0, {REG_FRAMES, 2'b00}, '0);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic push_item(input t_stim s);
        while (!quiet && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= s.mode;
        in_ch.frame_index  <= s.frame_index;
        in_ch.page_index   <= s.page_index;
        in_ch.referenced   <= s.referenced;
        in_ch.modified     <= s.modified;
        in_ch.access_time  <= s.access_time;
        in_ch.current_time <= s.current_time;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop sending and wait until every victim has come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (victims_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // run length guard
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_stim             s;
        int                frames;
        int                scan;
        int                bias;
        logic [1:0]        rm;
        logic [TIME_W-1:0] tick;
        int                frame_plan [PHASES];

        frame_plan = '{1, 2, 16, 31, 17, 0, -1, 8, -1, 5};

        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        quiet              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_WRITE;
        in_ch.frame_index  <= '0;
        in_ch.page_index   <= '0;
        in_ch.referenced   <= 1'b0;
        in_ch.modified     <= 1'b0;
        in_ch.access_time  <= '0;
        in_ch.current_time <= '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every frame so no select reads an unwritten entry
        for (int f = 0; f < NUM_FRAMES; f++) begin
            s.mode         = MODE_WRITE;
            s.frame_index  = FI_W'(f);
            s.page_index   = (f == 0) ? 16'h0000 : (f == 1) ? 16'hFFFF : PAGE_W'($urandom());
            {s.referenced, s.modified} = ~2'(f);
            s.access_time  = (f == 1) ? '1 : (f == 0 || f == 2) ? '0 : $urandom();
            s.current_time = $urandom();
            push_item(s);
        end

        // selects under the reset settings, ages wrapping at both ends
        s.mode = MODE_SELECT;
        s.current_time = '0;
        push_item(s);
        s.current_time = '1;
        push_item(s);
        s.current_time = 32'h8000_0000;
        push_item(s);

        settle();
        set_config(POL_NRU, 5'd16);
        push_item(s);

        // scan length zero behaves as one frame
        settle();
        set_config(POL_NRU, 5'd0);
        push_item(s);

        // scan length above the table size saturates
        settle();
        set_config(POL_LRU, 5'd31);
        push_item(s);

        // random phases over several register settings
        for (int p = 0; p < PHASES; p++) begin
            settle();
            frames = (frame_plan[p] < 0) ? $urandom_range(0, 31) : frame_plan[p];
            set_config(p[0] ? POL_NRU : POL_LRU, FIU_W'(frames));
            scan  = (frames == 0) ? 1 : (frames > NUM_FRAMES) ? NUM_FRAMES : frames;
            bias  = $urandom_range(0, 2);
            quiet <= (p == 4 || p == 5);
            case (p % 3)
                0:       tick = $urandom_range(0, 40);
                1:       tick = 32'hFFFF_FFE0 + $urandom_range(0, 31);
                default: tick = $urandom();
            endcase

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold the sender until the block has drained
                if (p == 3 && k == 30) settle();
                tick += $urandom_range(0, 6);
                s.mode        = ($urandom_range(99) < 45) ? MODE_SELECT : MODE_WRITE;
                s.frame_index = $urandom_range(1) ? FI_W'($urandom_range(0, scan - 1))
                                                  : FI_W'($urandom_range(0, NUM_FRAMES - 1));
                s.page_index  = PAGE_W'($urandom());
                // class mix: uniform, class zero rare, or mostly referenced
                case (bias)
                    0:       rm = 2'($urandom_range(0, 3));
                    1:       rm = ($urandom_range(99) < 5) ? 2'd0 : 2'($urandom_range(1, 3));
                    default: rm = ($urandom_range(99) < 10) ? 2'($urandom_range(0, 1))
                                                            : 2'($urandom_range(2, 3));
                endcase
                {s.referenced, s.modified} = rm;
                // access ticks near now, tied, random or ahead of now
                case ($urandom_range(0, 4))
                    0:       s.access_time = tick - $urandom_range(0, 64);
                    1:       s.access_time = tick - 7;
                    2:       s.access_time = $urandom();
                    3:       s.access_time = tick + $urandom_range(1, 16);
                    default: s.access_time = tick;
                endcase
                s.current_time = ($urandom_range(9) == 0) ? $urandom() : tick;
                push_item(s);
            end
        end

        settle();
        if (err_total == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pvs_pkg.sv
rtl/pvs_stream_if.sv
rtl/pvs_ram.sv
rtl/pvs_cfg_regs.sv
rtl/pvs_scan_engine.sv
rtl/page_victim_selector_unit.sv
tb/pvs_victim_checker.sv
tb/tb.sv
